@@ rtl/kvd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvd_pkg
// Shared types and codes of the key/value record block deframer.
// ----------------------------------------------------------------------------
package kvd_pkg;

    // Field widths of the channels
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 17;
    localparam int RKIND_W = 3;
    localparam int SEQ_W   = 64;
    localparam int ECODE_W = 3;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_FIRST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

    // Result kinds
    localparam logic [RKIND_W-1:0] RES_KEY    = 3'd0;
    localparam logic [RKIND_W-1:0] RES_VALUE  = 3'd1;
    localparam logic [RKIND_W-1:0] RES_RECORD = 3'd2;
    localparam logic [RKIND_W-1:0] RES_ERROR  = 3'd3;
    localparam logic [RKIND_W-1:0] RES_ENDED  = 3'd4;

    // Format error codes
    localparam logic [ECODE_W-1:0] ERR_KLEN = 3'd0;
    localparam logic [ECODE_W-1:0] ERR_KEY  = 3'd1;
    localparam logic [ECODE_W-1:0] ERR_VLEN = 3'd2;
    localparam logic [ECODE_W-1:0] ERR_VAL  = 3'd3;
    localparam logic [ECODE_W-1:0] ERR_TOMB = 3'd4;
    localparam logic [ECODE_W-1:0] ERR_SEQ  = 3'd5;

    // Record field sizes in bytes
    localparam int LEN_BYTES  = 4;
    localparam int TOMB_BYTES = 1;
    localparam int SEQ_BYTES  = 8;

    // Width of the fit compares: a 32-bit length plus the record trailer
    localparam int CMP_W = 34;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified input item; len is already clamped to the block limit
    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              len_zero;
    } t_cmd;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    // One result item
    typedef struct packed {
        logic [RKIND_W-1:0] kind;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic               tomb;
        logic [SEQ_W-1:0]   seq;
        logic [ECODE_W-1:0] code;
    } t_res;

endpackage

@@ rtl/kvd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvd_in_if / kvd_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface kvd_in_if import kvd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  block_len;

    modport source (output valid, output kind, output data_byte, output block_len,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input block_len,
                    output ready);
endinterface

interface kvd_out_if import kvd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RKIND_W-1:0] result_kind;
    logic [BYTE_W-1:0]  out_byte;
    logic               last_byte;
    logic               tombstone;
    logic [SEQ_W-1:0]   sequence_res;
    logic [ECODE_W-1:0] error_code;

    modport source (output valid, output result_kind, output out_byte,
                    output last_byte, output tombstone, output sequence_res,
                    output error_code, input ready);
    modport sink   (input valid, input result_kind, input out_byte,
                    input last_byte, input tombstone, input sequence_res,
                    input error_code, output ready);
endinterface

@@ rtl/kv_record_block_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kv_record_block_deframer
// Parses length-prefixed key/value records out of a stream of table blocks.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per transfer: a block start (first or following,
//   with its byte length), one data byte, or the end of the table.
//   o_out carries key bytes, value bytes, record-complete results with the
//   tombstone flag and 64-bit sequence number, format errors and the
//   iteration-ended marker. At most one result per input item.
//   i_cfg_valid/i_cfg_big_endian set the byte order of the length and
//   sequence fields; write it only while the block is idle. o_cfg_ready is 1.
// Timing:
//   An accepted item enters a four-entry command queue; the parser takes the
//   queue head and loads the result register, so a result reaches o_out
//   through the queue and the result register. Throughput is one item per
//   cycle while o_out is not stalled. When o_out stalls, the parser holds
//   and the queue fills; i_in.ready drops once four items wait. Reset
//   empties the queue, drops any pending result, returns the parser to
//   idle and selects little endian.
// ----------------------------------------------------------------------------
module kv_record_block_deframer import kvd_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvd_in_if.sink     i_in,
    kvd_out_if.source  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_big_endian
);

    logic  r_big_endian;
    logic  push;
    logic  full;
    logic  pop;
    t_cmd  cmd;
    t_head head;
    logic  out_valid;
    t_res  res;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
        end else if (i_cfg_valid) begin
            r_big_endian <= i_cfg_big_endian;
        end
    end

    kvd_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (cmd)
    );

    kvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    kvd_back #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_big_endian (r_big_endian),
        .i_head       (head),
        .o_pop        (pop),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (out_valid),
        .o_res        (res)
    );

    // Drive the result channel
    assign o_out.valid        = out_valid;
    assign o_out.result_kind  = res.kind;
    assign o_out.out_byte     = res.data;
    assign o_out.last_byte    = res.last;
    assign o_out.tombstone    = res.tomb;
    assign o_out.sequence_res = res.seq;
    assign o_out.error_code   = res.code;

endmodule

@@ rtl/kvd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvd_front
// Accepts input items, clamps block lengths and pushes commands to the queue.
// ----------------------------------------------------------------------------
module kvd_front import kvd_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = 65536
) (
    kvd_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    localparam int BLK_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int LW    = (BLK_W > LEN_W) ? BLK_W : LEN_W;

    logic [LW-1:0]    len_ext;
    logic [LW-1:0]    max_ext;
    logic [LEN_W-1:0] len_clamped;

    // Accept whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Clamp oversized block lengths to the block limit
    assign len_ext     = LW'(i_in.block_len);
    assign max_ext     = LW'(MAX_BLOCK_BYTES);
    assign len_clamped = (len_ext > max_ext) ? LEN_W'(max_ext) : i_in.block_len;

    always_comb begin
        o_cmd.op       = i_in.kind;
        o_cmd.data     = i_in.data_byte;
        o_cmd.len      = len_clamped;
        o_cmd.len_zero = (i_in.block_len == '0);
    end

endmodule

@@ rtl/kvd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvd_queue
// Short command FIFO that decouples the front end from the parser.
// ----------------------------------------------------------------------------
module kvd_queue import kvd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_pop,
    output t_head o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign do_pop       = i_pop && (r_cnt != '0);

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/kvd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvd_back
// Record parser: walks the record fields, checks fits, registers results.
// ----------------------------------------------------------------------------
module kvd_back import kvd_pkg::*; #(
    parameter int MAX_BLOCK_BYTES = 65536
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_big_endian,
    input  t_head i_head,
    output logic  o_pop,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    output t_res  o_res
);

    localparam int BLK_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int LW    = (BLK_W > LEN_W) ? BLK_W : LEN_W;

    // Parser phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_KLEN = 3'd1;
    localparam logic [2:0] PH_KEY  = 3'd2;
    localparam logic [2:0] PH_VLEN = 3'd3;
    localparam logic [2:0] PH_VAL  = 3'd4;
    localparam logic [2:0] PH_TOMB = 3'd5;
    localparam logic [2:0] PH_SEQ  = 3'd6;
    localparam logic [2:0] PH_END  = 3'd7;

    logic [2:0]       r_phase, n_phase;
    logic [BLK_W-1:0] r_blk, n_blk;
    logic [BLK_W-1:0] r_fld, n_fld;
    logic [2:0]       r_idx, n_idx;
    logic [SEQ_W-1:0] r_acc, n_acc;
    logic             r_tomb, n_tomb;
    logic             r_err, n_err;
    logic             r_out_valid, n_out_valid;
    t_res             r_res;

    logic             take;
    logic             fire;
    t_res             res;
    t_cmd             cmd;
    logic [BLK_W-1:0] len_blk;
    logic [BLK_W-1:0] blk_dec;
    logic [SEQ_W-1:0] acc_le;
    logic [SEQ_W-1:0] acc_nxt;
    logic [CMP_W-1:0] fld_len;
    logic [CMP_W-1:0] blk_room;
    logic             fld_last;
    logic             stopped;

    assign cmd         = i_head.cmd;
    assign take        = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop       = take;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    assign len_blk  = BLK_W'(LW'(cmd.len));
    assign blk_dec  = r_blk - 1'b1;
    assign fld_last = (r_fld == BLK_W'(1));
    assign stopped  = r_err || (r_phase == PH_IDLE) || (r_phase == PH_END);

    // Merge the incoming byte into the length or sequence accumulator
    always_comb begin
        acc_le = r_acc;
        for (int i = 0; i < SEQ_BYTES; i++) begin
            if (r_idx == 3'(i)) begin
                acc_le[8*i +: 8] = r_acc[8*i +: 8] | cmd.data;
            end
        end
        acc_nxt = i_big_endian ? {r_acc[SEQ_W-9:0], cmd.data} : acc_le;
    end

    assign fld_len  = CMP_W'(acc_nxt[31:0]);
    assign blk_room = CMP_W'(blk_dec);

    // Decode one command into next state and result
    always_comb begin
        n_phase = r_phase;
        n_blk   = r_blk;
        n_fld   = r_fld;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_tomb  = r_tomb;
        n_err   = r_err;
        fire    = 1'b0;
        res     = '0;

        if (take) begin
            case (cmd.op)
                KIND_FIRST, KIND_NEXT: begin
                    if (cmd.op == KIND_FIRST || !stopped) begin
                        n_err = (cmd.op == KIND_FIRST) ? 1'b0 : r_err;
                        n_blk = len_blk;
                        if (cmd.len_zero) begin
                            n_phase  = PH_END;
                            fire     = 1'b1;
                            res.kind = RES_ENDED;
                        end else begin
                            n_phase = PH_KLEN;
                            n_fld   = BLK_W'(LEN_BYTES);
                            n_idx   = '0;
                            n_acc   = '0;
                            n_tomb  = 1'b0;
                        end
                    end
                end
                KIND_DATA: begin
                    if (!stopped && r_blk != '0) begin
                        if (r_phase == PH_KLEN && r_fld == BLK_W'(LEN_BYTES) &&
                            r_blk < BLK_W'(LEN_BYTES)) begin
                            n_err    = 1'b1;
                            fire     = 1'b1;
                            res.kind = RES_ERROR;
                            res.code = ERR_KLEN;
                        end else begin
                            n_blk = blk_dec;
                            case (r_phase)
                                PH_KLEN: begin
                                    n_acc = acc_nxt;
                                    n_fld = r_fld - 1'b1;
                                    n_idx = r_idx + 1'b1;
                                    if (fld_last) begin
                                        n_acc = '0;
                                        n_idx = '0;
                                        if (fld_len > blk_room) begin
                                            n_err    = 1'b1;
                                            fire     = 1'b1;
                                            res.kind = RES_ERROR;
                                            res.code = ERR_KEY;
                                        end else if (fld_len + CMP_W'(LEN_BYTES) > blk_room) begin
                                            n_err    = 1'b1;
                                            fire     = 1'b1;
                                            res.kind = RES_ERROR;
                                            res.code = ERR_VLEN;
                                        end else if (fld_len == '0) begin
                                            n_phase = PH_VLEN;
                                            n_fld   = BLK_W'(LEN_BYTES);
                                        end else begin
                                            n_phase = PH_KEY;
                                            n_fld   = BLK_W'(fld_len);
                                        end
                                    end
                                end
                                PH_KEY, PH_VAL: begin
                                    n_fld    = r_fld - 1'b1;
                                    fire     = 1'b1;
                                    res.kind = (r_phase == PH_KEY) ? RES_KEY : RES_VALUE;
                                    res.data = cmd.data;
                                    res.last = fld_last;
                                    if (fld_last) begin
                                        n_acc = '0;
                                        n_idx = '0;
                                        if (r_phase == PH_KEY) begin
                                            n_phase = PH_VLEN;
                                            n_fld   = BLK_W'(LEN_BYTES);
                                        end else begin
                                            n_phase = PH_TOMB;
                                            n_fld   = BLK_W'(TOMB_BYTES);
                                        end
                                    end
                                end
                                PH_VLEN: begin
                                    n_acc = acc_nxt;
                                    n_fld = r_fld - 1'b1;
                                    n_idx = r_idx + 1'b1;
                                    if (fld_last) begin
                                        n_acc = '0;
                                        n_idx = '0;
                                        if (fld_len > blk_room) begin
                                            n_err    = 1'b1;
                                            fire     = 1'b1;
                                            res.kind = RES_ERROR;
                                            res.code = ERR_VAL;
                                        end else if (fld_len + CMP_W'(TOMB_BYTES) > blk_room) begin
                                            n_err    = 1'b1;
                                            fire     = 1'b1;
                                            res.kind = RES_ERROR;
                                            res.code = ERR_TOMB;
                                        end else if (fld_len + CMP_W'(TOMB_BYTES + SEQ_BYTES) >
                                                     blk_room) begin
                                            n_err    = 1'b1;
                                            fire     = 1'b1;
                                            res.kind = RES_ERROR;
                                            res.code = ERR_SEQ;
                                        end else if (fld_len == '0) begin
                                            n_phase = PH_TOMB;
                                            n_fld   = BLK_W'(TOMB_BYTES);
                                        end else begin
                                            n_phase = PH_VAL;
                                            n_fld   = BLK_W'(fld_len);
                                        end
                                    end
                                end
                                PH_TOMB: begin
                                    n_tomb  = (cmd.data != '0);
                                    n_phase = PH_SEQ;
                                    n_fld   = BLK_W'(SEQ_BYTES);
                                    n_acc   = '0;
                                    n_idx   = '0;
                                end
                                PH_SEQ: begin
                                    n_acc = acc_nxt;
                                    n_fld = r_fld - 1'b1;
                                    n_idx = r_idx + 1'b1;
                                    if (fld_last) begin
                                        fire     = 1'b1;
                                        res.kind = RES_RECORD;
                                        res.tomb = r_tomb;
                                        res.seq  = acc_nxt;
                                        n_phase  = PH_KLEN;
                                        n_fld    = BLK_W'(LEN_BYTES);
                                        n_acc    = '0;
                                        n_idx    = '0;
                                        n_tomb   = 1'b0;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                KIND_END: begin
                    if (!r_err && r_phase != PH_END) begin
                        n_phase  = PH_END;
                        n_blk    = '0;
                        fire     = 1'b1;
                        res.kind = RES_ENDED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold a result until the receiver takes it; replace it on a new command
    assign n_out_valid = take ? fire : (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_blk       <= '0;
            r_fld       <= '0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_tomb      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_blk       <= n_blk;
            r_fld       <= n_fld;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_tomb      <= n_tomb;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ tb/kv_record_block_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kv_record_block_deframer_tb
// Self-checking bench for the key/value record block deframer. A directed
// sequence covers idle, ended and error handling, block clamping and
// following blocks mid-record. Random tables of whole, truncated and
// over-long blocks follow in both byte orders. Every result transfer is
// checked field by field against an in-bench parser model, with random
// idle bursts on both channels.
// ----------------------------------------------------------------------------
module kv_record_block_deframer_tb;
    import kvd_pkg::*;

    localparam int BLOCK_LIMIT    = 65536;
    localparam int LEN_MAX        = (1 << LEN_W) - 1;
    localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 6;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int PHASE_ITEMS    = 140;
    localparam int NUM_PHASES     = 6;
    localparam int RECORD_FIXED   = 2 * LEN_BYTES + TOMB_BYTES + SEQ_BYTES;

    // Parser states of the model
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KLEN = 3'd1;
    localparam logic [2:0] ST_KEY  = 3'd2;
    localparam logic [2:0] ST_VLEN = 3'd3;
    localparam logic [2:0] ST_VAL  = 3'd4;
    localparam logic [2:0] ST_TOMB = 3'd5;
    localparam logic [2:0] ST_SEQ  = 3'd6;
    localparam logic [2:0] ST_END  = 3'd7;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        bit                wait_drain;
    } t_block_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_valid      = 1'b0;
    logic cfg_big_endian = 1'b0;
    logic cfg_ready;

    kvd_in_if  in_ch ();
    kvd_out_if out_ch ();

    t_block_item pending_items[$];
    t_res        expected_results[$];
    logic        drained = 1'b1;
    int          send_gap;
    int          recv_gap;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;
    int          fail_count;
    int          item_count;
    bit          gen_be;

    // Model state
    logic [2:0]       pr_phase;
    logic [LEN_W-1:0] pr_blk_left;
    logic [31:0]      pr_fld_left;
    logic [63:0]      pr_acc;
    logic             pr_tomb;
    logic             pr_err;
    logic             pr_be;

    always #5 i_clk = ~i_clk;

    kv_record_block_deframer #(
        .MAX_BLOCK_BYTES(BLOCK_LIMIT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (in_ch),
        .o_out           (out_ch),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_big_endian(cfg_big_endian)
    );

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic t_res make_res(logic [RKIND_W-1:0] kind, logic [BYTE_W-1:0] b,
                                      logic last, logic tomb, logic [SEQ_W-1:0] seq,
                                      logic [ECODE_W-1:0] code);
        t_res r;
        r.kind = kind;
        r.data = b;
        r.last = last;
        r.tomb = tomb;
        r.seq  = seq;
        r.code = code;
        return r;
    endfunction

    function automatic bit flag_error(input logic [ECODE_W-1:0] code, output t_res r);
        pr_err = 1'b1;
        r = make_res(RES_ERROR, 0, 0, 0, 0, code);
        return 1'b1;
    endfunction

    function automatic void begin_field(logic [2:0] st, logic [31:0] len);
        pr_phase    = st;
        pr_fld_left = len;
        pr_acc      = '0;
    endfunction

    function automatic void shift_in(logic [7:0] b, int unsigned size);
        int unsigned idx;
        if (pr_be) begin
            pr_acc = {pr_acc[55:0], b};
        end else begin
            idx    = (size - pr_fld_left) & 7;
            pr_acc = pr_acc | (64'(b) << (8 * idx));
        end
        pr_fld_left = pr_fld_left - 1;
    endfunction

    function automatic bit open_block(input logic [LEN_W-1:0] len, output t_res r);
        r = '0;
        pr_blk_left = (len > BLOCK_LIMIT) ? LEN_W'(BLOCK_LIMIT) : len;
        if (pr_blk_left == 0) begin
            pr_phase = ST_END;
            r = make_res(RES_ENDED, 0, 0, 0, 0, 0);
            return 1'b1;
        end
        begin_field(ST_KLEN, LEN_BYTES);
        pr_tomb = 1'b0;
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output t_res r);
        logic [63:0] rem;
        logic [63:0] n;
        logic [63:0] seq;
        logic        tomb;
        r = '0;
        if (pr_blk_left == 0) return 1'b0;
        // key length must fit before its first byte is taken
        if (pr_phase == ST_KLEN && pr_fld_left == LEN_BYTES && pr_blk_left < LEN_BYTES)
            return flag_error(ERR_KLEN, r);
        pr_blk_left = pr_blk_left - 1'b1;
        rem = 64'(pr_blk_left);
        case (pr_phase)
            ST_KLEN: begin
                shift_in(b, LEN_BYTES);
                if (pr_fld_left != 0) return 1'b0;
                n = {32'd0, pr_acc[31:0]};
                if (n > rem) return flag_error(ERR_KEY, r);
                if (rem - n < LEN_BYTES) return flag_error(ERR_VLEN, r);
                if (n == 0) begin_field(ST_VLEN, LEN_BYTES);
                else begin_field(ST_KEY, n[31:0]);
                return 1'b0;
            end
            ST_KEY: begin
                pr_fld_left = pr_fld_left - 1;
                if (pr_fld_left == 0) begin
                    begin_field(ST_VLEN, LEN_BYTES);
                    r = make_res(RES_KEY, b, 1, 0, 0, 0);
                end else begin
                    r = make_res(RES_KEY, b, 0, 0, 0, 0);
                end
                return 1'b1;
            end
            ST_VLEN: begin
                shift_in(b, LEN_BYTES);
                if (pr_fld_left != 0) return 1'b0;
                n = {32'd0, pr_acc[31:0]};
                if (n > rem) return flag_error(ERR_VAL, r);
                if (rem - n < TOMB_BYTES) return flag_error(ERR_TOMB, r);
                if (rem - n - TOMB_BYTES < SEQ_BYTES) return flag_error(ERR_SEQ, r);
                if (n == 0) begin_field(ST_TOMB, TOMB_BYTES);
                else begin_field(ST_VAL, n[31:0]);
                return 1'b0;
            end
            ST_VAL: begin
                pr_fld_left = pr_fld_left - 1;
                if (pr_fld_left == 0) begin
                    begin_field(ST_TOMB, TOMB_BYTES);
                    r = make_res(RES_VALUE, b, 1, 0, 0, 0);
                end else begin
                    r = make_res(RES_VALUE, b, 0, 0, 0, 0);
                end
                return 1'b1;
            end
            ST_TOMB: begin
                pr_tomb = (b != 0);
                begin_field(ST_SEQ, SEQ_BYTES);
                return 1'b0;
            end
            ST_SEQ: begin
                shift_in(b, SEQ_BYTES);
                if (pr_fld_left != 0) return 1'b0;
                seq  = pr_acc;
                tomb = pr_tomb;
                begin_field(ST_KLEN, LEN_BYTES);
                pr_tomb = 1'b0;
                r = make_res(RES_RECORD, 0, 0, tomb, seq, 0);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit deframe_predict(input logic [KIND_W-1:0] kind,
                                           input logic [BYTE_W-1:0] b,
                                           input logic [LEN_W-1:0] len, output t_res r);
        r = '0;
        case (kind)
            KIND_FIRST: begin
                pr_err = 1'b0;
                return open_block(len, r);
            end
            KIND_NEXT: begin
                if (pr_err || pr_phase == ST_IDLE || pr_phase == ST_END) return 1'b0;
                return open_block(len, r);
            end
            KIND_DATA: begin
                if (pr_err || pr_phase == ST_IDLE || pr_phase == ST_END) return 1'b0;
                return parse_byte(b, r);
            end
            default: begin
                if (pr_err || pr_phase == ST_END) return 1'b0;
                pr_phase    = ST_END;
                pr_blk_left = '0;
                r = make_res(RES_ENDED, 0, 0, 0, 0, 0);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check results, predict accepted items, watch for hangs
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_res got;
        t_res want;
        t_res pred;
        logic moved;
        if (!i_rst_n) begin
            pr_phase     = ST_IDLE;
            pr_blk_left  = '0;
            pr_fld_left  = '0;
            pr_acc       = '0;
            pr_tomb      = 1'b0;
            pr_err       = 1'b0;
            pr_be        = 1'b0;
            stall_cycles = 0;
            drained <= 1'b1;
        end else begin
            moved = 1'b0;
            // check the result transfer against the oldest expectation
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d", out_ch.result_kind);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 64'(want.kind), 64'(out_ch.result_kind));
                    check_field("out_byte", 64'(want.data), 64'(out_ch.out_byte));
                    check_field("last_byte", 64'(want.last), 64'(out_ch.last_byte));
                    check_field("tombstone", 64'(want.tomb), 64'(out_ch.tombstone));
                    check_field("sequence_res", want.seq, out_ch.sequence_res);
                    check_field("error_code", 64'(want.code), 64'(out_ch.error_code));
                end
            end
            // advance the model on each input transfer
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                if (deframe_predict(in_ch.kind, in_ch.data_byte, in_ch.block_len, pred))
                    expected_results.push_back(pred);
            end
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                pr_be = cfg_big_endian;
            end
            drained <= (expected_results.size() == 0);
            // end the run when nothing moves for too long
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $error("timeout with %0d results outstanding", expected_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer pending items with random idle bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        logic fire;
        fire = in_ch.valid && in_ch.ready;
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.kind      <= KIND_END;
            in_ch.data_byte <= '0;
            in_ch.block_len <= '0;
            send_gap = 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the offered item until it transfers
        end else begin
            if (fire) void'(pending_items.pop_front());
            if (send_gap != 0) send_gap--;
            else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
                send_gap = $urandom_range(1, 15);
            // a drain item waits until every expected result has come
            if (send_gap == 0 && pending_items.size() != 0 &&
                (!pending_items[0].wait_drain || (drained && !in_ch.valid))) begin
                in_ch.valid     <= 1'b1;
                in_ch.kind      <= pending_items[0].kind;
                in_ch.data_byte <= pending_items[0].data;
                in_ch.block_len <= pending_items[0].len;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall the result channel in random bursts
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (recv_gap != 0) recv_gap--;
            else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
                recv_gap = $urandom_range(1, 15);
            out_ch.ready <= (recv_gap == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                            logic [LEN_W-1:0] len, bit wait_drain = 1'b0);
        t_block_item it;
        it.kind       = kind;
        it.data       = data;
        it.len        = len;
        it.wait_drain = wait_drain;
        pending_items.push_back(it);
        item_count++;
    endtask

    task automatic add_data(logic [BYTE_W-1:0] b);
        add_item(KIND_DATA, b, LEN_W'($urandom_range(0, LEN_MAX)));
    endtask

    // Emit a length or sequence field in the current byte order
    task automatic add_field(logic [63:0] value, int nbytes);
        for (int i = 0; i < nbytes; i++)
            add_data(gen_be ? value[8 * (nbytes - 1 - i) +: 8] : value[8 * i +: 8]);
    endtask

    task automatic add_record(int klen, int vlen);
        add_field(64'(klen), LEN_BYTES);
        repeat (klen) add_data(8'($urandom));
        add_field(64'(vlen), LEN_BYTES);
        repeat (vlen) add_data(8'($urandom));
        add_data($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
        add_field({$urandom, $urandom}, SEQ_BYTES);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 3);
        if (r < 9) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // One table: up to three blocks of whole records, some sized wrong
    task automatic add_table(bit force_drain);
        int nblk;
        int nrec;
        int total;
        int blen;
        int mode;
        int kl[3];
        int vl[3];
        nblk = $urandom_range(1, 3);
        for (int bi = 0; bi < nblk; bi++) begin
            nrec  = $urandom_range(1, 3);
            total = 0;
            for (int ri = 0; ri < nrec; ri++) begin
                kl[ri] = pick_len();
                vl[ri] = pick_len();
                total += RECORD_FIXED + kl[ri] + vl[ri];
            end
            // short block forces a fit error; long one leaves a record cut off
            mode = $urandom_range(0, 11);
            blen = total;
            if (mode == 0)
                blen = total - $urandom_range(1, RECORD_FIXED + kl[nrec - 1] + vl[nrec - 1]);
            else if (mode == 1)
                blen = total + $urandom_range(4, 40);
            add_item(bi == 0 ? KIND_FIRST : KIND_NEXT, 8'($urandom), LEN_W'(blen),
                     bi == 0 && (force_drain || $urandom_range(0, 7) == 0));
            for (int ri = 0; ri < nrec; ri++) add_record(kl[ri], vl[ri]);
            if (mode == 1 || mode == 2) repeat ($urandom_range(1, 3)) add_data(8'($urandom));
        end
        // close the table in one of the allowed ways
        mode = $urandom_range(0, 7);
        if (mode <= 4) begin
            add_item(KIND_END, 8'($urandom), LEN_W'($urandom_range(0, LEN_MAX)));
        end else if (mode <= 6) begin
            add_item(KIND_NEXT, 8'($urandom), 0);
            if (mode == 6) add_item(KIND_END, 8'($urandom), LEN_W'($urandom_range(0, LEN_MAX)));
        end
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 3))
            add_item(KIND_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     LEN_W'($urandom_range(0, LEN_MAX)));
    endtask

    // Wait until all items transferred and all results arrived, then a margin
    task automatic settle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_byte_order(logic be);
        @(posedge i_clk);
        cfg_valid      <= 1'b1;
        cfg_big_endian <= be;
        do @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_be = be;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_END;
        in_ch.data_byte = '0;
        in_ch.block_len = '0;
        out_ch.ready    = 1'b0;
        fail_count      = 0;
        item_count      = 0;
        gen_be          = 1'b0;
        send_idle_pct   = 20;
        recv_idle_pct   = 20;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle, ended and error handling in reset byte order
        add_item(KIND_DATA, 8'hFF, LEN_W'(LEN_MAX));
        add_item(KIND_NEXT, 8'h00, 5);
        add_item(KIND_END, 8'h00, 0);
        add_item(KIND_END, 8'hFF, LEN_W'(LEN_MAX));
        add_item(KIND_DATA, 8'h00, 0);
        add_item(KIND_FIRST, 8'h00, 0);
        add_item(KIND_FIRST, 8'hFF, LEN_W'(LEN_MAX));
        add_field(1, LEN_BYTES);
        add_item(KIND_DATA, 8'hFF, 0);
        add_item(KIND_NEXT, 8'hFF, 3);
        add_item(KIND_DATA, 8'h5A, 0);
        add_item(KIND_DATA, 8'h11, 0);
        add_item(KIND_NEXT, 8'h00, 20);
        add_item(KIND_END, 8'h00, 0);
        add_item(KIND_FIRST, 8'h00, LEN_W'(BLOCK_LIMIT));
        add_item(KIND_END, 8'h00, 0);

        // random tables, alternating byte order; no idling in the last phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            write_byte_order(ph % 2 == 0);
            @(negedge i_clk);
            if (ph == NUM_PHASES - 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = 10 * $urandom_range(0, 4);
                recv_idle_pct = 10 * $urandom_range(0, 4);
            end
            add_table(1'b1);
            while (item_count < 25 + (ph + 1) * PHASE_ITEMS) begin
                if ($urandom_range(0, 5) == 0) add_noise();
                add_table(1'b0);
            end
        end
        settle();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ kv_record_block_deframer.f @@
rtl/kvd_pkg.sv
rtl/kvd_if.sv
rtl/kvd_front.sv
rtl/kvd_queue.sv
rtl/kvd_back.sv
rtl/kv_record_block_deframer.sv
tb/kv_record_block_deframer_tb.sv
